### design/csds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csds_pkg
// Shared types and constants for the C-SCAN disk request scheduler.
// ----------------------------------------------------------------------------
package csds_pkg;

	localparam int CYL_BITS        = 10;
	localparam int ID_BITS         = 8;
	localparam int RAW_BITS        = 16;
	localparam int ARR_BITS        = 16;
	localparam int KIND_BITS       = 2;
	localparam int TABLE_DEPTH_DEF = 16;
	localparam int QUEUE_DEPTH     = 4;
	localparam int APB_ADDR_BITS   = 3;
	localparam int APB_DATA_BITS   = 32;

	localparam logic [CYL_BITS-1:0] MAX_CYL_RESET = CYL_BITS'(199);

	// register index, taken from paddr above the byte lanes
	localparam logic REG_MAX_CYL = 1'b0;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_GRANT   = 2'd0,
		KIND_BAD_CYL = 2'd1,
		KIND_FULL    = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		QK_REQ,
		QK_BAD,
		QK_CMPL
	} q_kind_t;

	typedef struct packed {
		q_kind_t               kind;
		logic [ID_BITS-1:0]    who;
		logic [CYL_BITS-1:0]   cyl;
	} q_item_t;

	typedef struct packed {
		logic                  sweep;
		logic [ARR_BITS-1:0]   arrival;
		logic [ID_BITS-1:0]    who;
		logic [CYL_BITS-1:0]   cyl;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FREE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE
	} state_t;

endpackage

### design/csds_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csds_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module csds_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### design/csds_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csds_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module csds_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  csds_pkg::q_item_t push_item,
	output logic              full,
	input  logic              pop,
	output logic              avail,
	output csds_pkg::q_item_t pop_item
);
	import csds_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	q_item_t            slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign avail    = (count_q != '0);
	assign pop_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

### design/csds_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csds_front
// Input side: holds the configuration register, checks the cylinder range
// and sorts each accepted item into request, bad request or completion.
// ----------------------------------------------------------------------------
module csds_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [csds_pkg::APB_ADDR_BITS-1:0]    paddr,
	input  logic [csds_pkg::APB_DATA_BITS-1:0]    pwdata,
	output logic [csds_pkg::APB_DATA_BITS-1:0]    prdata,
	output logic                                  pready,
	input  logic                                  req_valid,
	output logic                                  req_stall,
	input  logic                                  op,
	input  logic [csds_pkg::ID_BITS-1:0]          requester_id,
	input  logic signed [csds_pkg::RAW_BITS-1:0]  cylinder,
	output logic                                  push,
	output csds_pkg::q_item_t                     push_item,
	input  logic                                  q_full
);
	import csds_pkg::*;

	logic [CYL_BITS-1:0] max_cyl_q;
	logic                reg_hit;
	logic                bad_cyl;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[APB_ADDR_BITS-1] == REG_MAX_CYL);
	assign prdata  = reg_hit ? APB_DATA_BITS'(max_cyl_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_cyl_q <= MAX_CYL_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			max_cyl_q <= pwdata[CYL_BITS-1:0];
		end
	end

	// negative, or above the configured top cylinder
	assign bad_cyl = cylinder[RAW_BITS-1] ||
		(RAW_BITS'(unsigned'(cylinder)) > RAW_BITS'(max_cyl_q));

	assign req_stall = q_full;
	assign push      = req_valid && !q_full;

	always_comb begin
		push_item.who = requester_id;
		push_item.cyl = cylinder[CYL_BITS-1:0];
		if (op) begin
			push_item.kind = QK_CMPL;
		end else if (bad_cyl) begin
			push_item.kind = QK_BAD;
		end else begin
			push_item.kind = QK_REQ;
		end
	end

endmodule

### design/csds_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csds_back
// Scheduler core: pending table, free slot search, C-SCAN pick over the
// table one entry a cycle, and the result register.
// ----------------------------------------------------------------------------
module csds_back #(
	parameter int TABLE_DEPTH = csds_pkg::TABLE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_avail,
	input  csds_pkg::q_item_t               q_item,
	output logic                            pop,
	output logic                            res_valid,
	input  logic                            res_stall,
	output logic [csds_pkg::KIND_BITS-1:0]  kind,
	output logic [csds_pkg::ID_BITS-1:0]    requester_id_res,
	output logic [csds_pkg::CYL_BITS-1:0]   cylinder_res
);
	import csds_pkg::*;

	localparam int IDX_W   = $clog2(TABLE_DEPTH);
	localparam int ENTRY_W = $bits(entry_t);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

	state_t               state_q, state_d;
	logic                 busy_q;
	logic [CYL_BITS-1:0]  head_q;
	logic                 cur_sweep_q;
	logic [ARR_BITS-1:0]  arr_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	q_item_t              item_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 pass_q;
	logic                 scan_v_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic                 found_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [CYL_BITS-1:0]  best_cyl_q;
	logic [ID_BITS-1:0]   best_who_q;
	logic [ARR_BITS-1:0]  best_age_q;

	logic                 res_valid_q;
	kind_t                kind_q;
	logic [ID_BITS-1:0]   who_q;
	logic [CYL_BITS-1:0]  cyl_q;

	logic                 out_free;
	logic                 ram_we;
	entry_t               wr_entry;
	logic [ENTRY_W-1:0]   ram_rdata;
	entry_t               rd_entry;
	logic                 target_sweep;
	logic [ARR_BITS-1:0]  rd_age;
	logic                 better;

	logic                 emit;
	kind_t                emit_kind;
	logic [ID_BITS-1:0]   emit_who;
	logic [CYL_BITS-1:0]  emit_cyl;

	assign out_free = !res_valid_q || !res_stall;

	// ---- pending table payload
	assign wr_entry.sweep   = (item_q.cyl > head_q) ? cur_sweep_q : ~cur_sweep_q;
	assign wr_entry.arrival = arr_q;
	assign wr_entry.who     = item_q.who;
	assign wr_entry.cyl     = item_q.cyl;

	csds_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata (wr_entry),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	assign rd_entry = entry_t'(ram_rdata);

	// ---- scan compare, one entry a cycle
	assign target_sweep = cur_sweep_q ^ pass_q;
	assign rd_age       = arr_q - rd_entry.arrival;
	assign better = scan_v_s1 && valid_q[idx_s1] && (rd_entry.sweep == target_sweep) &&
		(!found_q || (rd_entry.cyl < best_cyl_q) ||
		 ((rd_entry.cyl == best_cyl_q) && (rd_age > best_age_q)));

	// ---- next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_avail && out_free) begin
					unique case (q_item.kind)
						QK_REQ:  state_d = busy_q ? ST_FREE : ST_IDLE;
						QK_CMPL: state_d = busy_q ? ST_SCAN : ST_IDLE;
						QK_BAD:  state_d = ST_IDLE;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_FREE: begin
				if (!valid_q[idx_q] || (idx_q == IDX_LAST)) begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (idx_q == IDX_LAST) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (!found_q && !pass_q) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---- outputs of the sequencer
	always_comb begin
		pop       = 1'b0;
		ram_we    = 1'b0;
		emit      = 1'b0;
		emit_kind = KIND_GRANT;
		emit_who  = item_q.who;
		emit_cyl  = '0;
		unique case (state_q)
			ST_IDLE: begin
				pop      = q_avail && out_free;
				emit_who = q_item.who;
				if (pop && (q_item.kind == QK_BAD)) begin
					emit      = 1'b1;
					emit_kind = KIND_BAD_CYL;
				end else if (pop && (q_item.kind == QK_REQ) && !busy_q) begin
					emit      = 1'b1;
					emit_kind = KIND_GRANT;
					emit_cyl  = q_item.cyl;
				end
			end
			ST_FREE: begin
				ram_we = !valid_q[idx_q];
				if (valid_q[idx_q] && (idx_q == IDX_LAST)) begin
					emit      = 1'b1;
					emit_kind = KIND_FULL;
				end
			end
			ST_DECIDE: begin
				if (found_q) begin
					emit      = 1'b1;
					emit_kind = KIND_GRANT;
					emit_who  = best_who_q;
					emit_cyl  = best_cyl_q;
				end
			end
			ST_SCAN, ST_DRAIN: begin
			end
			default: begin
			end
		endcase
	end

	// ---- control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			busy_q      <= 1'b0;
			head_q      <= '0;
			cur_sweep_q <= 1'b0;
			arr_q       <= '0;
			valid_q     <= '0;
			idx_q       <= '0;
			pass_q      <= 1'b0;
			scan_v_s1   <= 1'b0;
			found_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			scan_v_s1 <= (state_q == ST_SCAN);

			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end

			if (better) begin
				found_q <= 1'b1;
			end

			unique case (state_q)
				ST_IDLE: begin
					idx_q   <= '0;
					pass_q  <= 1'b0;
					found_q <= 1'b0;
					if (pop && (q_item.kind == QK_REQ) && !busy_q) begin
						busy_q <= 1'b1;
						head_q <= q_item.cyl;
					end
				end
				ST_FREE: begin
					if (!valid_q[idx_q]) begin
						valid_q[idx_q] <= 1'b1;
						arr_q          <= arr_q + 1'b1;
					end else if (idx_q != IDX_LAST) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_SCAN: begin
					if (idx_q != IDX_LAST) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
				end
				ST_DECIDE: begin
					idx_q <= '0;
					if (found_q) begin
						valid_q[best_idx_q] <= 1'b0;
						head_q              <= best_cyl_q;
						if (pass_q) begin
							cur_sweep_q <= ~cur_sweep_q;
						end
					end else if (!pass_q) begin
						// current sweep empty: try the other one
						pass_q <= 1'b1;
					end else begin
						busy_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// ---- payload registers
	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= q_item;
		end
		idx_s1 <= idx_q;
		if (better) begin
			best_idx_q <= idx_s1;
			best_cyl_q <= rd_entry.cyl;
			best_who_q <= rd_entry.who;
			best_age_q <= rd_age;
		end
		if (emit) begin
			kind_q <= emit_kind;
			who_q  <= emit_who;
			cyl_q  <= emit_cyl;
		end
	end

	assign res_valid        = res_valid_q;
	assign kind             = kind_q;
	assign requester_id_res = who_q;
	assign cylinder_res     = cyl_q;

endmodule

### design/cscan_disk_request_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscan_disk_request_scheduler_unit
// C-SCAN disk cylinder scheduler: front classifier, item queue and back core.
// ----------------------------------------------------------------------------
// Order of events: an immediate grant or reject is registered straight from the popped item;
// a table-full reject follows a free slot search that finds no free entry; a completion
// grant follows the table scan, one entry a cycle, and a second scan pass when the sweeps swap.
// The core takes one item at a time: a queued request holds it through the free slot search
// and a swapping completion through both scan passes; a four-entry queue takes new items
// meanwhile. Reset clears valid bits, queue and head state at once.
module cscan_disk_request_scheduler_unit #(
	parameter int TABLE_DEPTH = csds_pkg::TABLE_DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [csds_pkg::APB_ADDR_BITS-1:0]    paddr,
	input  logic [csds_pkg::APB_DATA_BITS-1:0]    pwdata,
	output logic [csds_pkg::APB_DATA_BITS-1:0]    prdata,
	output logic                                  pready,
	input  logic                                  req_valid,
	output logic                                  req_stall,
	input  logic                                  op,
	input  logic [csds_pkg::ID_BITS-1:0]          requester_id,
	input  logic signed [csds_pkg::RAW_BITS-1:0]  cylinder,
	output logic                                  res_valid,
	input  logic                                  res_stall,
	output logic [csds_pkg::KIND_BITS-1:0]        kind,
	output logic [csds_pkg::ID_BITS-1:0]          requester_id_res,
	output logic [csds_pkg::CYL_BITS-1:0]         cylinder_res
);
	import csds_pkg::*;

	logic    push;
	q_item_t push_item;
	logic    q_full;
	logic    q_pop;
	logic    q_avail;
	q_item_t q_item;

	csds_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.op           (op),
		.requester_id (requester_id),
		.cylinder     (cylinder),
		.push         (push),
		.push_item    (push_item),
		.q_full       (q_full)
	);

	csds_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.avail     (q_avail),
		.pop_item  (q_item)
	);

	csds_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_avail          (q_avail),
		.q_item           (q_item),
		.pop              (q_pop),
		.res_valid        (res_valid),
		.res_stall        (res_stall),
		.kind             (kind),
		.requester_id_res (requester_id_res),
		.cylinder_res     (cylinder_res)
	);

endmodule

### bench/tb_cscan_disk_request_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cscan_disk_request_scheduler_unit
// Self-checking bench for the C-SCAN scheduler. A scoreboard holds its own
// copy of the pending table, head and sweep state, predicts any grant or
// reject for each accepted item and checks each outgoing transfer in order.
// Directed corner items come first, then random phases under several cylinder
// limits, with random idling on the request side and stalls on the result side.
// ----------------------------------------------------------------------------

typedef enum logic {
	OP_REQUEST = 1'b0,
	OP_DONE    = 1'b1
} sched_op_t;

typedef struct packed {
	csds_pkg::kind_t                  kind;
	logic [csds_pkg::ID_BITS-1:0]     who;
	logic [csds_pkg::CYL_BITS-1:0]    cyl;
} sched_outcome_t;

class cscan_grant_board;
	localparam int SLOTS = csds_pkg::TABLE_DEPTH_DEF;

	logic                             slot_used  [SLOTS];
	logic [csds_pkg::CYL_BITS-1:0]    slot_cyl   [SLOTS];
	logic [csds_pkg::ID_BITS-1:0]     slot_who   [SLOTS];
	logic                             slot_sweep [SLOTS];
	logic [csds_pkg::ARR_BITS-1:0]    slot_stamp [SLOTS];
	logic [csds_pkg::ARR_BITS-1:0]    stamp_now;
	bit                               busy;
	logic [csds_pkg::CYL_BITS-1:0]    head;
	logic                             sweep_now;
	logic [csds_pkg::CYL_BITS-1:0]    max_cyl;
	sched_outcome_t                   awaited_outcomes [$];
	int                               errors;

	function new();
		foreach (slot_used[i]) slot_used[i] = 1'b0;
		stamp_now = '0;
		busy      = 1'b0;
		head      = '0;
		sweep_now = 1'b0;
		max_cyl   = csds_pkg::MAX_CYL_RESET;
		errors    = 0;
	endfunction

	function void queue_outcome(csds_pkg::kind_t k, logic [csds_pkg::ID_BITS-1:0] who,
			logic [csds_pkg::CYL_BITS-1:0] cyl);
		sched_outcome_t o;
		o.kind = k;
		o.who  = who;
		o.cyl  = cyl;
		awaited_outcomes = {awaited_outcomes, o};
	endfunction

	// Lowest cylinder of the sweep; the older entry wins on equal cylinders.
	function int nearest_slot(logic sweep);
		int best;
		logic [csds_pkg::CYL_BITS-1:0] best_cyl;
		logic [csds_pkg::ARR_BITS-1:0] best_age, age;
		best     = -1;
		best_cyl = '0;
		best_age = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_used[i] && slot_sweep[i] == sweep) begin
				age = stamp_now - slot_stamp[i];
				if (best < 0 || slot_cyl[i] < best_cyl ||
						(slot_cyl[i] == best_cyl && age > best_age)) begin
					best     = i;
					best_cyl = slot_cyl[i];
					best_age = age;
				end
			end
		end
		return best;
	endfunction

	// Returns 0 only for an item the block ignores.
	function bit take_item(sched_op_t what, logic [csds_pkg::ID_BITS-1:0] who,
			logic [csds_pkg::RAW_BITS-1:0] raw);
		int k;
		int slot;
		logic [csds_pkg::CYL_BITS-1:0] cyl;
		if (what == OP_REQUEST) begin
			if (raw[csds_pkg::RAW_BITS-1] || raw > {6'b0, max_cyl}) begin
				queue_outcome(csds_pkg::KIND_BAD_CYL, who, '0);
				return 1'b1;
			end
			cyl = raw[csds_pkg::CYL_BITS-1:0];
			if (!busy) begin
				busy = 1'b1;
				head = cyl;
				queue_outcome(csds_pkg::KIND_GRANT, who, cyl);
				return 1'b1;
			end
			slot = -1;
			for (int i = SLOTS - 1; i >= 0; i--)
				if (!slot_used[i]) slot = i;
			if (slot < 0) begin
				queue_outcome(csds_pkg::KIND_FULL, who, '0);
				return 1'b1;
			end
			slot_used[slot]  = 1'b1;
			slot_cyl[slot]   = cyl;
			slot_who[slot]   = who;
			// an equal cylinder waits for the next sweep
			slot_sweep[slot] = (cyl > head) ? sweep_now : ~sweep_now;
			slot_stamp[slot] = stamp_now;
			stamp_now        = stamp_now + 1'b1;
			return 1'b1;
		end
		if (!busy)
			return 1'b0;
		k = nearest_slot(sweep_now);
		if (k < 0) begin
			k = nearest_slot(~sweep_now);
			if (k < 0) begin
				busy = 1'b0;
				return 1'b1;
			end
			sweep_now = ~sweep_now;
		end
		slot_used[k] = 1'b0;
		head         = slot_cyl[k];
		queue_outcome(csds_pkg::KIND_GRANT, slot_who[k], slot_cyl[k]);
		return 1'b1;
	endfunction

	function void check_outcome(logic [csds_pkg::KIND_BITS-1:0] k,
			logic [csds_pkg::ID_BITS-1:0] who, logic [csds_pkg::CYL_BITS-1:0] cyl);
		sched_outcome_t want;
		if (awaited_outcomes.size() == 0) begin
			$error("unexpected transfer: kind %0d requester_id_res %0d cylinder_res %0d",
				k, who, cyl);
			errors++;
			return;
		end
		want = awaited_outcomes.pop_front();
		if (k !== want.kind) begin
			$error("kind: expected %0d, got %0d", want.kind, k);
			errors++;
		end
		if (who !== want.who) begin
			$error("requester_id_res: expected %0d, got %0d", want.who, who);
			errors++;
		end
		if (cyl !== want.cyl) begin
			$error("cylinder_res: expected %0d, got %0d", want.cyl, cyl);
			errors++;
		end
	endfunction
endclass

module tb_cscan_disk_request_scheduler_unit;

	localparam int LIMIT  = 600000;
	localparam int SETTLE = 250;
	localparam logic [csds_pkg::APB_ADDR_BITS-1:0] ADDR_MAX_CYL =
		csds_pkg::APB_ADDR_BITS'(4 * int'(csds_pkg::REG_MAX_CYL));

	typedef enum int {
		CH_MIXED,
		CH_FLOOD,
		CH_DRAIN
	} chunk_style_t;

	logic                                  clk;
	logic                                  arst_n;
	logic                                  psel;
	logic                                  penable;
	logic                                  pwrite;
	logic [csds_pkg::APB_ADDR_BITS-1:0]    paddr;
	logic [csds_pkg::APB_DATA_BITS-1:0]    pwdata;
	logic [csds_pkg::APB_DATA_BITS-1:0]    prdata;
	logic                                  pready;
	logic                                  req_valid;
	logic                                  req_stall;
	logic                                  op;
	logic [csds_pkg::ID_BITS-1:0]          requester_id;
	logic signed [csds_pkg::RAW_BITS-1:0]  cylinder;
	logic                                  res_valid;
	logic                                  res_stall = 1'b0;
	logic [csds_pkg::KIND_BITS-1:0]        kind;
	logic [csds_pkg::ID_BITS-1:0]          requester_id_res;
	logic [csds_pkg::CYL_BITS-1:0]         cylinder_res;

	cscan_grant_board sb;
	int  effective_items = 0;
	int  stall_left      = 0;
	int  cycle_count     = 0;
	bit  calm            = 1'b0;

	cscan_disk_request_scheduler_unit #(
		.TABLE_DEPTH(csds_pkg::TABLE_DEPTH_DEF)
	) dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.req_valid        (req_valid),
		.req_stall        (req_stall),
		.op               (op),
		.requester_id     (requester_id),
		.cylinder         (cylinder),
		.res_valid        (res_valid),
		.res_stall        (res_stall),
		.kind             (kind),
		.requester_id_res (requester_id_res),
		.cylinder_res     (cylinder_res)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_cscan_disk_request_scheduler_unit NOT OK");
		$finish;
	end

	function automatic int draw_wait();
		return calm ? 0 : int'($urandom_range(0, 18));
	endfunction

	// Check the outgoing transfer before noting the incoming one.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall)
				sb.check_outcome(kind, requester_id_res, cylinder_res);
			if (req_valid && !req_stall) begin
				void'(sb.take_item(sched_op_t'(op), requester_id, cylinder));
				effective_items++;
			end
		end
	end

	always @(posedge clk) begin
		if (res_valid && !res_stall)
			stall_left = draw_wait();
		if (stall_left > 0) begin
			res_stall <= 1'b1;
			stall_left--;
		end else begin
			res_stall <= 1'b0;
		end
	end

	task automatic send_item(input sched_op_t what, input logic [csds_pkg::ID_BITS-1:0] who,
			input logic [csds_pkg::RAW_BITS-1:0] cyl);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid    <= 1'b1;
		op           <= what;
		requester_id <= who;
		cylinder     <= cyl;
		do @(posedge clk); while (req_stall);
	endtask

	// Drop valid, let every awaited transfer arrive, then let queued work settle.
	task automatic wait_drained();
		req_valid <= 1'b0;
		while (sb.awaited_outcomes.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write the limit, then read it back with psel held through both transfers.
	task automatic set_cylinder_limit(input logic [csds_pkg::CYL_BITS-1:0] value);
		logic [csds_pkg::APB_DATA_BITS-1:0] back;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_MAX_CYL;
		pwdata  <= csds_pkg::APB_DATA_BITS'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.max_cyl = value;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		back = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (back[csds_pkg::CYL_BITS-1:0] !== value) begin
			$error("cylinder limit: expected %0d, got %0d", value,
				back[csds_pkg::CYL_BITS-1:0]);
			sb.errors++;
		end
	endtask

	function automatic logic [csds_pkg::RAW_BITS-1:0] pick_cylinder(int bad_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < bad_pct / 2)
			return {1'b1, 15'($urandom)};
		if (roll < bad_pct)
			return 16'($urandom_range(int'(sb.max_cyl) + 1, 32767));
		roll = $urandom_range(0, 9);
		if (roll < 3)
			return 16'(sb.head);
		if (roll == 3)
			return 16'd0;
		if (roll == 4)
			return 16'(sb.max_cyl);
		return 16'($urandom_range(0, int'(sb.max_cyl)));
	endfunction

	task automatic run_chunk(input chunk_style_t style, input int count);
		int done_pct;
		int bad_pct;
		case (style)
			CH_FLOOD: begin
				done_pct = 0;
				bad_pct  = 10;
			end
			CH_DRAIN: begin
				done_pct = 85;
				bad_pct  = 10;
			end
			default: begin
				done_pct = 45;
				bad_pct  = 15;
			end
		endcase
		repeat (count) begin
			if (int'($urandom_range(0, 99)) < done_pct)
				send_item(OP_DONE, 8'($urandom), 16'($urandom));
			else
				send_item(OP_REQUEST, 8'($urandom), pick_cylinder(bad_pct));
		end
	endtask

	// Open with a flood so the table fills under every limit.
	task automatic random_phase(input int target);
		int start;
		start = effective_items;
		run_chunk(CH_FLOOD, 20);
		while (effective_items - start < target) begin
			calm = ($urandom_range(0, 4) == 0);
			run_chunk(chunk_style_t'($urandom_range(0, 2)), $urandom_range(8, 40));
		end
		calm = 1'b0;
	endtask

	initial begin
		logic [csds_pkg::CYL_BITS-1:0] limits [4];
		sb           = new();
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		req_valid    = 1'b0;
		op           = OP_REQUEST;
		requester_id = '0;
		cylinder     = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle grant, then the cylinder rejects at both signs and just past the limit
		send_item(OP_REQUEST, 8'h00, 16'd0);
		send_item(OP_REQUEST, 8'hFF, 16'hFFFF);
		send_item(OP_REQUEST, 8'hA5, 16'h8000);
		send_item(OP_REQUEST, 8'h5A, 16'h7FFF);
		send_item(OP_REQUEST, 8'h01, 16'd200);
		// queue above the head, equal to the head, and repeats of one cylinder
		send_item(OP_REQUEST, 8'h02, 16'd199);
		send_item(OP_REQUEST, 8'h03, 16'd0);
		send_item(OP_REQUEST, 8'h04, 16'd0);
		send_item(OP_REQUEST, 8'h05, 16'd199);
		send_item(OP_REQUEST, 8'h06, 16'd100);
		// serve the sweep, swap, go idle, then complete while idle
		repeat (7) send_item(OP_DONE, 8'($urandom), 16'($urandom));

		random_phase(150);
		limits = '{10'd1023, 10'd0, 10'($urandom_range(1, 1022)), 10'd7};
		foreach (limits[i]) begin
			wait_drained();
			set_cylinder_limit(limits[i]);
			random_phase(160);
		end
		wait_drained();

		if (sb.errors == 0 && sb.awaited_outcomes.size() == 0)
			$display("tb_cscan_disk_request_scheduler_unit OK");
		else
			$display("tb_cscan_disk_request_scheduler_unit NOT OK");
		$finish;
	end

endmodule

### files.f
design/csds_pkg.sv
design/csds_ram.sv
design/csds_fifo.sv
design/csds_front.sv
design/csds_back.sv
design/cscan_disk_request_scheduler_unit.sv
bench/tb_cscan_disk_request_scheduler_unit.sv
